/* rtl/i2cts_pkg.sv */
// Shared codes, reset values and limits for the I2C temperature sensor.
`timescale 1ns / 1ps
`default_nettype none

package i2cts_pkg;

   // Request codes
   localparam logic [2:0] REQ_START_READ  = 3'd0;
   localparam logic [2:0] REQ_START_WRITE = 3'd1;
   localparam logic [2:0] REQ_STOP        = 3'd2;
   localparam logic [2:0] REQ_READ_BYTE   = 3'd3;
   localparam logic [2:0] REQ_WRITE_BYTE  = 3'd4;
   localparam logic [2:0] REQ_POLL        = 3'd5;
   localparam logic [2:0] REQ_SAMPLE      = 3'd6;

   // Register select (low two pointer bits)
   localparam logic [1:0] SEL_TEMP = 2'd0;
   localparam logic [1:0] SEL_CONF = 2'd1;
   localparam logic [1:0] SEL_HIGH = 2'd2;
   localparam logic [1:0] SEL_HYST = 2'd3;

   // Configuration bits
   localparam int unsigned CFG_SHUTDOWN_BIT = 0;
   localparam int unsigned CFG_INTMODE_BIT  = 1;

   // Byte counter: reads end after two bytes, writes saturate at three
   localparam logic [1:0] CNT_BUF_END = 2'd2;
   localparam logic [1:0] CNT_MAX     = 2'd3;

   localparam logic [7:0] IDLE_BYTE = 8'hff;

   // Temperatures in half degrees, 9-bit two's complement
   typedef logic signed [8:0] temp_type;

   localparam temp_type TEMP_RESET = 9'sd45;
   localparam temp_type HIGH_RESET = 9'sd160;
   localparam temp_type HYST_RESET = 9'sd150;
   localparam temp_type TEMP_MIN   = 9'sb110010010;   // -110
   localparam temp_type TEMP_MAX   = 9'sb011111010;   // 250

endpackage

`default_nettype wire

/* rtl/i2cts_if.sv */
// Request and response channel interfaces of the I2C temperature sensor.
`timescale 1ns / 1ps
`default_nettype none

interface i2cts_req_if;
   logic                 valid;
   logic                 ready;
   logic [2:0]           req_type;
   logic [7:0]           data_byte;
   i2cts_pkg::temp_type  temp_sample;

   modport source (output valid, output req_type, output data_byte, output temp_sample,
                   input ready);
   modport sink (input valid, input req_type, input data_byte, input temp_sample,
                 output ready);
endinterface

interface i2cts_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] read_data;
   logic       alarm;

   modport source (output valid, output read_data, output alarm, input ready);
   modport sink (input valid, input read_data, input alarm, output ready);
endinterface

`default_nettype wire

/* rtl/i2c_temp_sensor_thermostat_top.sv */
// Top level of the I2C temperature sensor with thermostat alarm.
//
// Channels: req_chan takes one bus event or tick per beat (start read, start
// write, stop, read byte, write byte, poll tick, sensor sample). rsp_chan
// returns exactly one beat per request: read_data (0xff unless a read byte
// hits the two-byte transfer buffer) and the alarm level after the event.
// Both use valid/ready; a beat moves when both are high.
//
// Path: request beat to response valid goes through the input register, then
// the state update and the response register in one pass.
// Throughput: one request per cycle while rsp_chan.ready is high; the state
// update is a single pass of muxes and four 9-bit signed compares.
//
// Stall: the input register and the response register form a two-deep
// pipe; with rsp_chan.ready low the block keeps taking one more beat, then
// drops req_chan.ready until the response leaves.
//
// Reset (synchronous, active high): pipe empty, pointer and configuration
// zero, temperature 22.5 C, high limit 80 C, hysteresis 75 C, buffer all
// ones, byte count zero, event and alarm low.
`timescale 1ns / 1ps
`default_nettype none

module i2c_temp_sensor_thermostat_top (
   input  wire           clock,
   input  wire           reset,
   i2cts_req_if.sink     req_chan,
   i2cts_rsp_if.source   rsp_chan
);

   // Input register
   logic                 s1_valid_ff;
   logic [2:0]           s1_type_ff;
   logic [7:0]           s1_data_ff;
   i2cts_pkg::temp_type  s1_sample_ff;

   // Response register
   logic                 out_valid_ff;
   logic [7:0]           out_data_ff;
   logic                 out_alarm_ff;

   // Sensor state
   logic [7:0]           pointer_ff, pointer_in;
   logic [7:0]           config_ff, config_in;
   i2cts_pkg::temp_type  temp_ff, temp_in;
   i2cts_pkg::temp_type  high_ff, high_in;
   i2cts_pkg::temp_type  hyst_ff, hyst_in;
   logic [7:0]           buf0_ff, buf0_in;
   logic [7:0]           buf1_ff, buf1_in;
   logic [1:0]           count_ff, count_in;
   logic                 event_ff, event_in;
   logic                 alarm_ff, alarm_in;
   logic [7:0]           rd_in;

   logic                 advance;
   logic                 req_take;
   logic [1:0]           sel;
   i2cts_pkg::temp_type  sel_temp;
   logic [7:0]           wr_b0;
   logic [7:0]           wr_b1;
   i2cts_pkg::temp_type  wr_temp;
   logic                 over_high;
   logic                 under_hyst;

   // Pipe control
   assign advance        = s1_valid_ff && (!out_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !s1_valid_ff || advance;
   assign req_take       = req_chan.valid && req_chan.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_chan.ready) begin
         s1_valid_ff <= req_chan.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_type_ff   <= req_chan.req_type;
         s1_data_ff   <= req_chan.data_byte;
         s1_sample_ff <= req_chan.temp_sample;
      end
   end

   // Addressed register and write-back values
   assign sel = pointer_ff[1:0];

   always_comb begin
      case (sel)
         i2cts_pkg::SEL_TEMP: sel_temp = temp_ff;
         i2cts_pkg::SEL_HIGH: sel_temp = high_ff;
         default:             sel_temp = hyst_ff;
      endcase
   end

   // Buffer after a write byte; the other byte keeps its current contents
   assign wr_b0   = (count_ff == 2'd1) ? s1_data_ff : buf0_ff;
   assign wr_b1   = (count_ff == 2'd2) ? s1_data_ff : buf1_ff;
   assign wr_temp = {wr_b0, wr_b1[7]};

   assign over_high  = temp_ff > high_ff;
   assign under_hyst = temp_ff < hyst_ff;

   // Next state for the request in the input register
   always_comb begin
      pointer_in = pointer_ff;
      config_in  = config_ff;
      temp_in    = temp_ff;
      high_in    = high_ff;
      hyst_in    = hyst_ff;
      buf0_in    = buf0_ff;
      buf1_in    = buf1_ff;
      count_in   = count_ff;
      event_in   = event_ff;
      alarm_in   = alarm_ff;
      rd_in      = i2cts_pkg::IDLE_BYTE;

      case (s1_type_ff)
         i2cts_pkg::REQ_START_READ: begin
            if (sel == i2cts_pkg::SEL_CONF) begin
               buf0_in = config_ff;
               buf1_in = i2cts_pkg::IDLE_BYTE;
            end else begin
               buf0_in = sel_temp[8:1];
               buf1_in = {sel_temp[0], 7'd0};
            end
            if (config_ff[i2cts_pkg::CFG_INTMODE_BIT]) begin
               alarm_in = 1'b0;
            end
            count_in = 2'd0;
         end
         i2cts_pkg::REQ_START_WRITE: begin
            count_in = 2'd0;
         end
         i2cts_pkg::REQ_READ_BYTE: begin
            if (count_ff < i2cts_pkg::CNT_BUF_END) begin
               rd_in    = count_ff[0] ? buf1_ff : buf0_ff;
               count_in = count_ff + 2'd1;
            end
         end
         i2cts_pkg::REQ_WRITE_BYTE: begin
            if (count_ff == 2'd0) begin
               pointer_in = s1_data_ff;
            end else if (count_ff <= i2cts_pkg::CNT_BUF_END) begin
               buf0_in = wr_b0;
               buf1_in = wr_b1;
               case (sel)
                  i2cts_pkg::SEL_TEMP: temp_in   = wr_temp;
                  i2cts_pkg::SEL_CONF: config_in = wr_b0;
                  i2cts_pkg::SEL_HIGH: high_in   = wr_temp;
                  default:             hyst_in   = wr_temp;
               endcase
            end
            if (count_ff != i2cts_pkg::CNT_MAX) begin
               count_in = count_ff + 2'd1;
            end
         end
         i2cts_pkg::REQ_POLL: begin
            if (config_ff[i2cts_pkg::CFG_SHUTDOWN_BIT]) begin
               alarm_in = 1'b0;
            end else if (config_ff[i2cts_pkg::CFG_INTMODE_BIT]) begin
               if (!event_ff && over_high) begin
                  event_in = 1'b1;
                  alarm_in = 1'b1;
               end else if (event_ff && under_hyst) begin
                  event_in = 1'b0;
                  alarm_in = 1'b1;
               end
            end else begin
               // Comparator mode: hysteresis clear wins when both hold
               if (under_hyst) begin
                  alarm_in = 1'b0;
               end else if (over_high) begin
                  alarm_in = 1'b1;
               end
            end
         end
         i2cts_pkg::REQ_SAMPLE: begin
            if (s1_sample_ff < i2cts_pkg::TEMP_MIN) begin
               temp_in = i2cts_pkg::TEMP_MIN;
            end else if (s1_sample_ff > i2cts_pkg::TEMP_MAX) begin
               temp_in = i2cts_pkg::TEMP_MAX;
            end else begin
               temp_in = s1_sample_ff;
            end
         end
         default: begin
            // stop and unused codes leave the state alone
         end
      endcase
   end

   // State registers
   always_ff @(posedge clock) begin
      if (reset) begin
         pointer_ff <= 8'd0;
         config_ff  <= 8'd0;
         temp_ff    <= i2cts_pkg::TEMP_RESET;
         high_ff    <= i2cts_pkg::HIGH_RESET;
         hyst_ff    <= i2cts_pkg::HYST_RESET;
         buf0_ff    <= i2cts_pkg::IDLE_BYTE;
         buf1_ff    <= i2cts_pkg::IDLE_BYTE;
         count_ff   <= 2'd0;
         event_ff   <= 1'b0;
         alarm_ff   <= 1'b0;
      end else if (advance) begin
         pointer_ff <= pointer_in;
         config_ff  <= config_in;
         temp_ff    <= temp_in;
         high_ff    <= high_in;
         hyst_ff    <= hyst_in;
         buf0_ff    <= buf0_in;
         buf1_ff    <= buf1_in;
         count_ff   <= count_in;
         event_ff   <= event_in;
         alarm_ff   <= alarm_in;
      end
   end

   // Response register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_data_ff  <= rd_in;
         out_alarm_ff <= alarm_in;
      end
   end

   assign rsp_chan.valid     = out_valid_ff;
   assign rsp_chan.read_data = out_data_ff;
   assign rsp_chan.alarm     = out_alarm_ff;

   // Checks
   a_advance_fills_out: assert property (@(posedge clock) disable iff (reset)
      advance |=> out_valid_ff)
      else $error("response register not loaded after advance");

   a_idle_byte: assert property (@(posedge clock) disable iff (reset)
      advance && (s1_type_ff != i2cts_pkg::REQ_READ_BYTE)
      |=> out_data_ff == i2cts_pkg::IDLE_BYTE)
      else $error("non-read request returned data");

   a_shutdown_quiet: assert property (@(posedge clock) disable iff (reset)
      advance && (s1_type_ff == i2cts_pkg::REQ_POLL)
      && config_ff[i2cts_pkg::CFG_SHUTDOWN_BIT] |=> !alarm_ff && !out_alarm_ff)
      else $error("alarm raised in shutdown");

   a_ready_only_when_full: assert property (@(posedge clock) disable iff (reset)
      !req_chan.ready |-> s1_valid_ff && out_valid_ff && !rsp_chan.ready)
      else $error("request side stalled without a full pipe");

   a_out_alarm_tracks: assert property (@(posedge clock) disable iff (reset)
      advance |=> out_alarm_ff == alarm_ff)
      else $error("response alarm differs from alarm state");

endmodule

`default_nettype wire
